FILE: design/snt_pkg.sv
// Shared types and constants for the skeleton neighbourhood test core.
// Used by snt_ram's users and the top level; depends on nothing.
package snt_pkg;

    localparam int OFS_W      = 11;
    localparam int SIZE_W     = 11;
    localparam int DIST_W     = 24;
    localparam int COORD_W    = 10;
    localparam int PIX_W      = 23;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_NB     = 8;

    // output buffer: depth, pointer and count widths
    localparam int OBUF_DEPTH = 8;
    localparam int OBUF_AW    = 3;
    localparam int OBUF_CW    = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MIN_SQ_DIST  = 2'd2,
        REG_MAX_SQ_DIST  = 2'd3
    } cfg_reg_t;

    // neighbour offsets, raster order around the center
    localparam logic signed [1:0] NB_DX [NUM_NB] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                     2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] NB_DY [NUM_NB] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                     2'sd0, 2'sd1, 2'sd1, 2'sd1};

    // pixel word as stored in the line stores, foreground bit lowest
    typedef struct packed {
        logic signed [OFS_W-1:0] offset_row;
        logic signed [OFS_W-1:0] offset_col;
        logic                    is_foreground;
    } pixel_t;

    // result item, row lowest
    typedef struct packed {
        logic               is_skeleton;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
    } result_t;

    // per-neighbour differences
    typedef struct packed {
        logic signed [12:0] ex;
        logic signed [12:0] ey;
        logic signed [11:0] qix;
        logic signed [11:0] qiy;
        logic        [11:0] cheb;
    } lane_diff_t;

    // per-neighbour squared terms
    typedef struct packed {
        logic [23:0] d2;
        logic [21:0] r2i;
        logic [11:0] cheb;
    } lane_sq_t;

endpackage

FILE: design/snt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module snt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/skeleton_neighbourhood_test_core.sv
// Top level of the skeleton neighbourhood test core.
// Depends on snt_pkg and snt_ram (two line stores).

// Takes one pixel item per clock in raster order while s_tready is high and, for
// every interior pixel, returns one result item (row, column, skeleton bit) once
// the pixel completing its 3x3 neighbourhood arrives; border pixels give none.
// The two previous rows sit in two line-store RAMs of MAX_WIDTH words, read in the
// cycle before the window shift and written back in the cycle of the shift; a
// fill mark stands in for clearing them, so no clearing pass follows reset.
// Eight neighbour lanes run in parallel through a difference, a square and a
// compare stage. An eight-entry output buffer lets the input keep flowing while
// results wait; s_tready drops only once eight results are outstanding.
// Writing image_width or image_height restarts the frame at row 0, column 0.
module skeleton_neighbourhood_test_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: is_foreground [0], offset_col [11:1], offset_row [22:12], zero [23]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [snt_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: out_row [9:0], out_col [19:10], is_skeleton [20], zero [23:21]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [snt_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [snt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [snt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // ---------------- configuration ----------------
    logic [snt_pkg::SIZE_W-1:0] img_w_reg, img_h_reg;
    logic [snt_pkg::DIST_W-1:0] min_sq_reg, max_sq_reg;
    logic                       cfg_wr;
    logic                       size_wr;
    logic [WW-1:0]              w_eff;
    logic [HW-1:0]              h_eff;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign size_wr   = cfg_wr && (cfg_addr == snt_pkg::REG_IMAGE_WIDTH ||
                                  cfg_addr == snt_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg  <= snt_pkg::SIZE_W'(1024);
            img_h_reg  <= snt_pkg::SIZE_W'(1024);
            min_sq_reg <= '0;
            max_sq_reg <= snt_pkg::DIST_W'(8388608);
        end else if (cfg_wr) begin
            case (snt_pkg::cfg_reg_t'(cfg_addr))
                snt_pkg::REG_IMAGE_WIDTH:  img_w_reg  <= cfg_data[snt_pkg::SIZE_W-1:0];
                snt_pkg::REG_IMAGE_HEIGHT: img_h_reg  <= cfg_data[snt_pkg::SIZE_W-1:0];
                snt_pkg::REG_MIN_SQ_DIST:  min_sq_reg <= cfg_data;
                snt_pkg::REG_MAX_SQ_DIST:  max_sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate frame size into 3..MAX
    always_comb begin
        if (img_w_reg < snt_pkg::SIZE_W'(3)) begin
            w_eff = WW'(3);
        end else if (32'(img_w_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(img_w_reg);
        end
        if (img_h_reg < snt_pkg::SIZE_W'(3)) begin
            h_eff = HW'(3);
        end else if (32'(img_h_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(img_h_reg);
        end
    end

    // ---------------- input, counters, credits ----------------
    logic                          accept;
    logic                          emit;
    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [WW-1:0]                 fill_reg, fill_next;
    logic                          col_hit;
    logic [CW-1:0]                 col_m1;
    logic [RW-1:0]                 row_m1;
    logic [CW+snt_pkg::COORD_W-1:0] col_m1_ext;
    logic [RW+snt_pkg::COORD_W-1:0] row_m1_ext;
    logic [snt_pkg::OBUF_CW-1:0]   credit_reg, credit_next;
    logic                          obuf_pop;

    assign s_tready   = credit_reg != snt_pkg::OBUF_CW'(snt_pkg::OBUF_DEPTH);
    assign accept     = s_tvalid && s_tready;
    assign emit       = (32'(row_reg) >= 32'd2) && (32'(col_reg) >= 32'd2);
    assign col_hit    = WW'(col_reg) < fill_reg;
    assign col_m1     = col_reg - 1'b1;
    assign row_m1     = row_reg - 1'b1;
    assign col_m1_ext = {{snt_pkg::COORD_W{1'b0}}, col_m1};
    assign row_m1_ext = {{snt_pkg::COORD_W{1'b0}}, row_m1};

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        fill_next = fill_reg;
        if (size_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (WW'(col_reg) == fill_reg) begin
                fill_next = fill_reg + 1'b1;
            end
            if (WW'(col_reg) + 1'b1 == w_eff) begin
                col_next = '0;
                if (HW'(row_reg) + 1'b1 == h_eff) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        credit_next = credit_reg;
        if (accept && emit && !obuf_pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (obuf_pop && !(accept && emit)) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    // ---------------- line stores ----------------
    logic                             s1_valid_reg;
    logic                             s1_hit_reg;
    logic                             s1_emit_reg;
    logic [CW-1:0]                    s1_col_reg;
    snt_pkg::pixel_t                  s1_px_reg;
    logic [snt_pkg::COORD_W-1:0]      s1_orow_reg, s1_ocol_reg;
    logic [snt_pkg::PIX_W-1:0]        ls0_rd, ls1_rd;
    snt_pkg::pixel_t                  ls0_px, ls1_px;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_hit_reg  <= col_hit;
            s1_emit_reg <= emit;
            s1_col_reg  <= col_reg;
            s1_px_reg   <= snt_pkg::pixel_t'(s_tdata[snt_pkg::PIX_W-1:0]);
            s1_orow_reg <= row_m1_ext[snt_pkg::COORD_W-1:0];
            s1_ocol_reg <= col_m1_ext[snt_pkg::COORD_W-1:0];
        end
    end

    // entries beyond the fill mark were never written and read as zero
    assign ls0_px = s1_hit_reg ? snt_pkg::pixel_t'(ls0_rd) : '0;
    assign ls1_px = s1_hit_reg ? snt_pkg::pixel_t'(ls1_rd) : '0;

    snt_ram #(
        .WIDTH (snt_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line0 (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_px_reg),
        .rd_addr (col_reg),
        .rd_data (ls0_rd)
    );

    snt_ram #(
        .WIDTH (snt_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line1 (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (ls0_px),
        .rd_addr (col_reg),
        .rd_data (ls1_rd)
    );

    // ---------------- 3x3 window ----------------
    snt_pkg::pixel_t             win_reg [3][3];
    logic                        wv_valid_reg;
    logic [snt_pkg::COORD_W-1:0] wv_row_reg, wv_col_reg;

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= ls1_px;
            win_reg[1][2] <= ls0_px;
            win_reg[2][2] <= s1_px_reg;
            wv_row_reg    <= s1_orow_reg;
            wv_col_reg    <= s1_ocol_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_valid_reg <= 1'b0;
        end else begin
            wv_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    // ---------------- neighbour lanes ----------------
    logic                              sa_valid_reg, sb_valid_reg;
    snt_pkg::lane_diff_t               sa_lane_reg [snt_pkg::NUM_NB];
    logic signed [snt_pkg::OFS_W-1:0]  sa_qx_reg, sa_qy_reg;
    logic                              sa_fg_reg, sb_fg_reg;
    logic [snt_pkg::COORD_W-1:0]       sa_row_reg, sa_col_reg, sb_row_reg, sb_col_reg;
    snt_pkg::lane_sq_t                 sb_lane_reg [snt_pkg::NUM_NB];
    logic [21:0]                       sb_r2q_reg;
    logic [snt_pkg::NUM_NB-1:0]        lane_hit;
    logic signed [21:0]                qx_sq, qy_sq;

    assign qx_sq = sa_qx_reg * sa_qx_reg;
    assign qy_sq = sa_qy_reg * sa_qy_reg;

    for (genvar i = 0; i < snt_pkg::NUM_NB; i++) begin : g_lane
        localparam int RI = 1 + int'(snt_pkg::NB_DY[i]);
        localparam int CI = 1 + int'(snt_pkg::NB_DX[i]);

        snt_pkg::pixel_t    nb;
        snt_pkg::lane_diff_t diff;
        logic signed [11:0] qix, qiy;
        logic signed [12:0] ex, ey;
        logic        [11:0] aex, aey, amax;
        logic signed [25:0] ex_sq, ey_sq;
        logic signed [23:0] qix_sq, qiy_sq;
        logic        [22:0] bound;

        assign nb   = win_reg[RI][CI];
        assign qix  = 12'(nb.offset_col) + 12'(snt_pkg::NB_DX[i]);
        assign qiy  = 12'(nb.offset_row) + 12'(snt_pkg::NB_DY[i]);
        assign ex   = 13'(qix) - 13'(win_reg[1][1].offset_col);
        assign ey   = 13'(qiy) - 13'(win_reg[1][1].offset_row);
        assign aex  = ex[12] ? 12'(-ex) : ex[11:0];
        assign aey  = ey[12] ? 12'(-ey) : ey[11:0];
        assign amax = (aex > aey) ? aex : aey;

        always_comb begin
            diff.ex   = ex;
            diff.ey   = ey;
            diff.qix  = qix;
            diff.qiy  = qiy;
            diff.cheb = (amax == 12'd0) ? 12'd1 : amax;
        end

        always_ff @(posedge aclk) begin
            sa_lane_reg[i] <= diff;
        end

        assign ex_sq  = sa_lane_reg[i].ex * sa_lane_reg[i].ex;
        assign ey_sq  = sa_lane_reg[i].ey * sa_lane_reg[i].ey;
        assign qix_sq = sa_lane_reg[i].qix * sa_lane_reg[i].qix;
        assign qiy_sq = sa_lane_reg[i].qiy * sa_lane_reg[i].qiy;

        always_ff @(posedge aclk) begin
            sb_lane_reg[i].d2   <= 24'(ex_sq[22:0]) + 24'(ey_sq[22:0]);
            sb_lane_reg[i].r2i  <= 22'(qix_sq[20:0]) + 22'(qiy_sq[20:0]);
            sb_lane_reg[i].cheb <= sa_lane_reg[i].cheb;
        end

        // r2(Qi) - r2(Q) <= cheb, kept unsigned
        assign bound       = 23'(sb_r2q_reg) + 23'(sb_lane_reg[i].cheb);
        assign lane_hit[i] = (sb_lane_reg[i].d2 >= min_sq_reg) &&
                             (sb_lane_reg[i].d2 <= max_sq_reg) &&
                             (23'(sb_lane_reg[i].r2i) <= bound);
    end

    always_ff @(posedge aclk) begin
        sa_qx_reg  <= win_reg[1][1].offset_col;
        sa_qy_reg  <= win_reg[1][1].offset_row;
        sa_fg_reg  <= win_reg[1][1].is_foreground;
        sa_row_reg <= wv_row_reg;
        sa_col_reg <= wv_col_reg;
        sb_r2q_reg <= 22'(qx_sq[20:0]) + 22'(qy_sq[20:0]);
        sb_fg_reg  <= sa_fg_reg;
        sb_row_reg <= sa_row_reg;
        sb_col_reg <= sa_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end else begin
            sa_valid_reg <= wv_valid_reg;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    // ---------------- output buffer ----------------
    snt_pkg::result_t            obuf_reg [snt_pkg::OBUF_DEPTH];
    snt_pkg::result_t            res;
    logic [snt_pkg::OBUF_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [snt_pkg::OBUF_CW-1:0] cnt_reg, cnt_next;
    logic                        obuf_push;

    assign obuf_push = sb_valid_reg;
    assign obuf_pop  = m_tvalid && m_tready;

    always_comb begin
        res.is_skeleton = sb_fg_reg && (|lane_hit);
        res.out_col     = sb_col_reg;
        res.out_row     = sb_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (obuf_push) begin
            obuf_reg[wr_ptr_reg] <= res;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (obuf_push && !obuf_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (obuf_pop && !obuf_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (obuf_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (obuf_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = snt_pkg::M_TDATA_W'(obuf_reg[rd_ptr_reg]);

`ifndef SYNTH
    // outstanding results never exceed the buffer
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= snt_pkg::OBUF_CW'(snt_pkg::OBUF_DEPTH))
        else $error("result credit above buffer depth");

    // a push never lands on a full buffer
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        obuf_push |-> (cnt_reg != snt_pkg::OBUF_CW'(snt_pkg::OBUF_DEPTH) || obuf_pop))
        else $error("output buffer overflow");

    // buffered results are covered by credits
    a_cnt_le_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= credit_reg)
        else $error("buffer holds uncredited results");

    // write-back stays inside the filled part of the line stores
    a_wb_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (WW'(s1_col_reg) < fill_reg))
        else $error("line store write beyond fill mark");

    // column and row counters stay inside the frame
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (WW'(col_reg) < w_eff) && (HW'(row_reg) < h_eff))
        else $error("position counter outside frame");
`endif

endmodule
